FILE: hw/rtl/pgc_pkg.sv
// Shared types, constants and register indexes of the proximity gain calculator
`timescale 1ns / 1ps
`default_nettype none

package pgc_pkg;

	// default sizes
	localparam int DEF_MAX_TARGETS = 16;
	localparam int DEF_COORD_BITS  = 16;

	// fixed field widths
	localparam int IDX_BITS     = 4;
	localparam int NUM_BITS     = 5;
	localparam int REG_IDX_BITS = 3;

	// configuration register indexes
	localparam logic [REG_IDX_BITS-1:0] REG_TARGET_RADIUS = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_RADIUS = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_USE_GLOBAL    = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_X      = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_GLOBAL_Y      = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_NUM_TARGETS   = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_MODE          = 3'd6;

	// register reset values that do not depend on coordinate width
	localparam logic [NUM_BITS-1:0] RST_NUM_TARGETS = 5'd3;

	// operation and mode codes
	localparam logic OP_SET_SOURCE = 1'b0;
	localparam logic OP_SET_TARGET = 1'b1;
	localparam logic MODE_BEAM     = 1'b0;
	localparam logic MODE_PROXY    = 1'b1;

	// which point the distance is measured toward
	typedef enum logic [1:0] {
		PT_GLOBAL,
		PT_TABLE,
		PT_ITEM
	} pgc_pt_t;

	// controller to datapath commands
	typedef struct packed {
		logic                take_src;
		logic                take_tgt;
		logic                rd_en;
		pgc_pt_t             pt_sel;
		logic                use_glb_r;
		logic                diff;
		logic                square;
		logic                sum;
		logic                root_step;
		logic                clamp;
		logic                div_step;
		logic                finish;
		logic                emit;
		logic                emit_last;
		logic [IDX_BITS-1:0] emit_target;
	} pgc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mode;
		logic use_global;
		logic out_free;
	} pgc_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pgc_if.sv
// Item and result channel interfaces of the proximity gain calculator
`timescale 1ns / 1ps
`default_nettype none

interface pgc_item_if #(
	parameter int COORD_BITS = pgc_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [pgc_pkg::IDX_BITS-1:0] index;
	logic [COORD_BITS-1:0]        pos_x;
	logic [COORD_BITS-1:0]        pos_y;

	modport source (output valid, op, index, pos_x, pos_y, input ready);
	modport sink   (input valid, op, index, pos_x, pos_y, output ready);
endinterface

interface pgc_result_if #(
	parameter int COORD_BITS = pgc_pkg::DEF_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic [pgc_pkg::IDX_BITS-1:0] target;
	logic [COORD_BITS:0]          gain;
	logic                         last;

	modport source (output valid, target, gain, last, input ready);
	modport sink   (input valid, target, gain, last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pgc_ram.sv
// Generic single write port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module pgc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pgc_datapath.sv
// Datapath: configuration, positions, target table, distance and gain arithmetic
`timescale 1ns / 1ps
`default_nettype none

module pgc_datapath #(
	parameter int MAX_TARGETS = pgc_pkg::DEF_MAX_TARGETS,
	parameter int COORD_BITS  = pgc_pkg::DEF_COORD_BITS,
	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
	localparam int CW = $clog2(MAX_TARGETS + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pgc_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS:0]              cfg_data,
	input  logic [pgc_pkg::IDX_BITS-1:0]     item_index,
	input  logic [COORD_BITS-1:0]            item_x,
	input  logic [COORD_BITS-1:0]            item_y,
	input  pgc_pkg::pgc_cmd_t                cmd,
	input  logic [AW-1:0]                    rd_addr,
	output pgc_pkg::pgc_status_t             status,
	output logic [CW-1:0]                    n_active,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [pgc_pkg::IDX_BITS-1:0]     out_target,
	output logic [COORD_BITS:0]              out_gain,
	output logic                             out_last
);

	import pgc_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int RW   = C + 1;
	localparam int SQW  = 2 * C;
	localparam int RADW = 2 * C + 2;
	localparam int REMW = C + 2;
	localparam logic [RW-1:0] ONE  = {1'b1, {C{1'b0}}};
	localparam logic [RW-1:0] HALF = {2'b01, {(C-1){1'b0}}};

	// configuration registers
	logic [RW-1:0]       tr_q;
	logic [RW-1:0]       gr_q;
	logic                use_glb_q;
	logic [C-1:0]        gx_q;
	logic [C-1:0]        gy_q;
	logic [NUM_BITS-1:0] num_q;
	logic                mode_q;

	// positions and table state
	logic [C-1:0]           src_x_q;
	logic [C-1:0]           src_y_q;
	logic [C-1:0]           item_x_q;
	logic [C-1:0]           item_y_q;
	logic [MAX_TARGETS-1:0] vld_q;
	logic                   vld_rd_s1;
	logic [AW-1:0]          wr_addr;
	logic [2*C-1:0]         rd_data;

	// arithmetic registers
	logic [C-1:0]    dx_q;
	logic [C-1:0]    dy_q;
	logic [SQW-1:0]  sqx_q;
	logic [SQW-1:0]  sqy_q;
	logic [RADW-1:0] rad_q;
	logic [REMW-1:0] rrem_q;
	logic [RW-1:0]   root_q;
	logic [RW-1:0]   drem_q;
	logic [RW-1:0]   dsh_q;
	logic [RW-1:0]   quo_q;
	logic [RW-1:0]   glb_gain_q;
	logic [RW-1:0]   res_gain_q;

	// output register
	logic                out_valid_q;
	logic [IDX_BITS-1:0] out_target_q;
	logic [RW-1:0]       out_gain_q;
	logic                out_last_q;

	// combinational helpers
	logic [C-1:0]      px;
	logic [C-1:0]      py;
	logic [C-1:0]      dx_d;
	logic [C-1:0]      dy_d;
	logic [REMW+1:0]   rrem_sh;
	logic [REMW+1:0]   trial;
	logic [RW-1:0]     rsel;
	logic [RW-1:0]     clamped;
	logic [RW:0]       dtrial;
	logic [RW:0]       rsel_x;
	logic [RW-1:0]     gain_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q      <= HALF;
			gr_q      <= HALF;
			use_glb_q <= 1'b0;
			gx_q      <= '0;
			gy_q      <= '0;
			num_q     <= RST_NUM_TARGETS;
			mode_q    <= MODE_PROXY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_RADIUS: tr_q      <= cfg_data;
				REG_GLOBAL_RADIUS: gr_q      <= cfg_data;
				REG_USE_GLOBAL:    use_glb_q <= cfg_data[0];
				REG_GLOBAL_X:      gx_q      <= cfg_data[C-1:0];
				REG_GLOBAL_Y:      gy_q      <= cfg_data[C-1:0];
				REG_NUM_TARGETS:   num_q     <= cfg_data[NUM_BITS-1:0];
				REG_MODE:          mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// active count saturates at the table size
	assign n_active = (int'(num_q) > MAX_TARGETS) ? CW'(MAX_TARGETS) : CW'(num_q);

	// source position and table valid bits
	assign wr_addr = AW'(item_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q <= '0;
			src_y_q <= '0;
			vld_q   <= '0;
		end else begin
			if (cmd.take_src) begin
				src_x_q <= item_x;
				src_y_q <= item_y;
			end
			if (cmd.take_tgt) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// latest target position and valid bit of the entry being read
	always_ff @(posedge clk) begin
		if (cmd.take_tgt) begin
			item_x_q <= item_x;
			item_y_q <= item_y;
		end
		if (cmd.rd_en) begin
			vld_rd_s1 <= vld_q[rd_addr];
		end
	end

	// target position table
	pgc_ram #(
		.WIDTH (2 * C),
		.DEPTH (MAX_TARGETS)
	) u_table (
		.clk   (clk),
		.we    (cmd.take_tgt),
		.waddr (wr_addr),
		.wdata ({item_x, item_y}),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// point select, an entry never written reads as the origin
	always_comb begin
		case (cmd.pt_sel)
			PT_GLOBAL: begin
				px = gx_q;
				py = gy_q;
			end
			PT_TABLE: begin
				px = vld_rd_s1 ? rd_data[2*C-1:C] : '0;
				py = vld_rd_s1 ? rd_data[C-1:0] : '0;
			end
			PT_ITEM: begin
				px = item_x_q;
				py = item_y_q;
			end
			default: begin
				px = '0;
				py = '0;
			end
		endcase
	end

	// absolute differences
	assign dx_d = (src_x_q > px) ? src_x_q - px : px - src_x_q;
	assign dy_d = (src_y_q > py) ? src_y_q - py : py - src_y_q;

	// square root step: two radicand bits in, one root bit out
	assign rrem_sh = {rrem_q, rad_q[RADW-1 -: 2]};
	assign trial   = (REMW+2)'({root_q, 2'b01});

	// radius select, distance clamp and division step
	assign rsel    = cmd.use_glb_r ? gr_q : tr_q;
	assign clamped = (root_q > rsel) ? rsel : root_q;
	assign dtrial  = {drem_q, dsh_q[RW-1]};
	assign rsel_x  = {1'b0, rsel};
	assign gain_d  = (rsel == '0) ? '0 : ONE - quo_q;

	// distance and gain registers
	always_ff @(posedge clk) begin
		if (cmd.diff) begin
			dx_q <= dx_d;
			dy_q <= dy_d;
		end
		if (cmd.square) begin
			sqx_q <= SQW'(dx_q) * SQW'(dx_q);
			sqy_q <= SQW'(dy_q) * SQW'(dy_q);
		end
		if (cmd.sum) begin
			rad_q  <= RADW'(sqx_q) + RADW'(sqy_q);
			rrem_q <= '0;
			root_q <= '0;
		end
		if (cmd.root_step) begin
			rad_q <= rad_q << 2;
			if (rrem_sh >= trial) begin
				rrem_q <= REMW'(rrem_sh - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rrem_q <= REMW'(rrem_sh);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.clamp) begin
			drem_q <= clamped >> 1;
			dsh_q  <= {clamped[0], {C{1'b0}}};
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			dsh_q <= dsh_q << 1;
			if (dtrial >= rsel_x) begin
				drem_q <= RW'(dtrial - rsel_x);
				quo_q  <= {quo_q[RW-2:0], 1'b1};
			end else begin
				drem_q <= RW'(dtrial);
				quo_q  <= {quo_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (cmd.use_glb_r) begin
				glb_gain_q <= gain_d;
			end else begin
				res_gain_q <= (use_glb_q && glb_gain_q > gain_d) ? glb_gain_q : gain_d;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_target_q <= cmd.emit_target;
			out_gain_q   <= res_gain_q;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_target = out_target_q;
	assign out_gain   = out_gain_q;
	assign out_last   = out_last_q;

	// status to the controller
	assign status.mode       = mode_q;
	assign status.use_global = use_glb_q;
	assign status.out_free   = !out_valid_q || out_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/pgc_ctrl.sv
// Controller: sequences item transfers, gain jobs, root and divide iterations
`timescale 1ns / 1ps
`default_nettype none

module pgc_ctrl #(
	parameter int MAX_TARGETS = pgc_pkg::DEF_MAX_TARGETS,
	parameter int COORD_BITS  = pgc_pkg::DEF_COORD_BITS,
	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
	localparam int CW = $clog2(MAX_TARGETS + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	input  logic                         item_op,
	input  logic [pgc_pkg::IDX_BITS-1:0] item_index,
	output logic                         item_ready,
	input  pgc_pkg::pgc_status_t         status,
	input  logic [CW-1:0]                n_active,
	output pgc_pkg::pgc_cmd_t            cmd,
	output logic [AW-1:0]                rd_addr
);

	import pgc_pkg::*;

	localparam int SW = $clog2(COORD_BITS + 2);
	localparam logic [SW-1:0] LAST_STEP = SW'(COORD_BITS);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIFF,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_CLAMP,
		ST_DIV,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       t_q;
	logic [CW-1:0]       n_q;
	logic [IDX_BITS-1:0] tgt_q;
	logic                multi_q;
	logic                glb_q;
	pgc_pt_t             pt_q;
	logic [SW-1:0]       step_q;

	logic accept;
	logic idx_in_table;
	logic idx_active;
	logic last_t;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign idx_in_table = int'(item_index) < MAX_TARGETS;
	assign idx_active   = int'(item_index) < int'(n_active);
	assign last_t       = (t_q == n_q - CW'(1));
	assign rd_addr      = AW'(t_q);

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.pt_sel      = pt_q;
		cmd.use_glb_r   = glb_q;
		cmd.take_src    = accept && (item_op == OP_SET_SOURCE);
		cmd.take_tgt    = accept && (item_op == OP_SET_TARGET) && idx_in_table;
		cmd.rd_en       = (state_q == ST_FETCH);
		cmd.diff        = (state_q == ST_DIFF);
		cmd.square      = (state_q == ST_SQUARE);
		cmd.sum         = (state_q == ST_SUM);
		cmd.root_step   = (state_q == ST_ROOT);
		cmd.clamp       = (state_q == ST_CLAMP);
		cmd.div_step    = (state_q == ST_DIV);
		cmd.finish      = (state_q == ST_FINISH);
		cmd.emit        = (state_q == ST_EMIT) && status.out_free;
		cmd.emit_last   = !multi_q || last_t;
		cmd.emit_target = multi_q ? IDX_BITS'(t_q) : tgt_q;
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			t_q     <= '0;
			n_q     <= '0;
			tgt_q   <= '0;
			multi_q <= 1'b0;
			glb_q   <= 1'b0;
			pt_q    <= PT_ITEM;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q    <= n_active;
						t_q    <= '0;
						tgt_q  <= item_index;
						glb_q  <= status.use_global;
						step_q <= '0;
						if (item_op == OP_SET_SOURCE) begin
							multi_q <= 1'b1;
							if (status.mode == MODE_BEAM || n_active == '0) begin
								state_q <= ST_IDLE;
							end else if (status.use_global) begin
								pt_q    <= PT_GLOBAL;
								state_q <= ST_DIFF;
							end else begin
								pt_q    <= PT_TABLE;
								state_q <= ST_FETCH;
							end
						end else begin
							multi_q <= 1'b0;
							if (!idx_in_table || !idx_active) begin
								state_q <= ST_IDLE;
							end else if (status.use_global) begin
								pt_q    <= PT_GLOBAL;
								state_q <= ST_DIFF;
							end else begin
								pt_q    <= PT_ITEM;
								state_q <= ST_DIFF;
							end
						end
					end
				end
				ST_FETCH:  state_q <= ST_DIFF;
				ST_DIFF:   state_q <= ST_SQUARE;
				ST_SQUARE: state_q <= ST_SUM;
				ST_SUM: begin
					step_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= ST_CLAMP;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_CLAMP: state_q <= ST_DIV;
				ST_DIV: begin
					if (step_q == LAST_STEP) begin
						step_q  <= '0;
						state_q <= ST_FINISH;
					end else begin
						step_q <= step_q + SW'(1);
					end
				end
				ST_FINISH: begin
					// global gain done first, then the target job
					if (glb_q) begin
						glb_q <= 1'b0;
						if (multi_q) begin
							pt_q    <= PT_TABLE;
							state_q <= ST_FETCH;
						end else begin
							pt_q    <= PT_ITEM;
							state_q <= ST_DIFF;
						end
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						if (multi_q && !last_t) begin
							t_q     <= t_q + CW'(1);
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/proximity_gain_calculator.sv
// Top level of the proximity gain calculator
//
// Channels: item (op, index, pos_x, pos_y) in, result (target, gain, last) out,
// both valid/ready; a transfer happens when valid and ready are high at a clock edge.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while the block is idle, as the block itself does not enforce this.
// One shared distance unit: a restoring square root and a restoring divider,
// each producing one bit per cycle.
// Set target: one result, for that target.
// Set source in proxy mode: one result per active target.
// With the global floor on, one extra gain job runs before the first result.
// Items that give no result free the block in the cycle after their transfer.
// item.ready is high only while the controller is idle, so one item is in work at
// a time; the output register lets the next item enter while the last result waits.
// A stalled result channel holds the controller before the next result load.
// Reset clears the source, the table valid bits and all control; the registers
// return to their documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module proximity_gain_calculator #(
	parameter int MAX_TARGETS = pgc_pkg::DEF_MAX_TARGETS,
	parameter int COORD_BITS  = pgc_pkg::DEF_COORD_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pgc_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS:0]              cfg_data,
	pgc_item_if.sink                         item,
	pgc_result_if.source                     result
);

	import pgc_pkg::*;

	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CW = $clog2(MAX_TARGETS + 1);
	localparam logic [COORD_BITS:0] ONE = {1'b1, {COORD_BITS{1'b0}}};

	pgc_cmd_t      cmd;
	pgc_status_t   status;
	logic [CW-1:0] n_active;
	logic [AW-1:0] rd_addr;
	logic          ctl_ready;

	assign item.ready = ctl_ready;

	// controller
	pgc_ctrl #(
		.MAX_TARGETS (MAX_TARGETS),
		.COORD_BITS  (COORD_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_index (item.index),
		.item_ready (ctl_ready),
		.status     (status),
		.n_active   (n_active),
		.cmd        (cmd),
		.rd_addr    (rd_addr)
	);

	// datapath
	pgc_datapath #(
		.MAX_TARGETS (MAX_TARGETS),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_index (item.index),
		.item_x     (item.pos_x),
		.item_y     (item.pos_y),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.status     (status),
		.n_active   (n_active),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_target (result.target),
		.out_gain   (result.gain),
		.out_last   (result.last)
	);

	// a result load never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result.valid || result.ready))
		else $error("result load while output register is occupied");

	// a target set beyond the active count leaves the block free at once
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.op == OP_SET_TARGET &&
		 int'(item.index) >= int'(n_active)) |=> item.ready)
		else $error("inactive target set kept the block busy");

	// a source move in beam mode gives no work
	assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready && item.op == OP_SET_SOURCE &&
		 status.mode == MODE_BEAM) |=> item.ready)
		else $error("beam mode source move kept the block busy");

	// gain stays within unity
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.gain <= ONE))
		else $error("gain above unity");

endmodule

`default_nettype wire
